/* sv/tdpt_pkg.sv */
`timescale 1ns / 1ps

package tdpt_pkg;

  // fixed widths of the stream payloads
  localparam int CANDIDATE_W   = 32;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 8;
  localparam int WIDTH_DEFAULT = 32;

  // first odd divisor tried and the step between divisors
  localparam int FIRST_DIVISOR = 3;
  localparam int DIVISOR_STEP  = 2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new candidate
    logic div_start;  // begin a remainder computation
    logic div_step;   // one restoring-division bit
    logic next_div;   // advance to the next odd divisor
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic lt_two;     // candidate is 0 or 1
    logic is_two;     // candidate is 2
    logic is_even;    // candidate is even
    logic sq_le;      // divisor squared does not exceed candidate
    logic div_last;   // current division bit is the last one
    logic rem_zero;   // remainder of the last division is zero
  } dp_stat_t;

endpackage

/* sv/trial_division_prime_test_top.sv */
`timescale 1ns / 1ps

// Trial-division primality test. Each beat on the slave side carries one
// unsigned candidate; one beat on the master side answers 1 if it is prime.
// Only the low WIDTH bits of the candidate are tested. Zero, one, two and
// other even values are answered without any division; an odd value is
// divided by the odd divisors in turn (3, 5, 7, ... up to the square root
// or the first one that divides). The time is set by the bit-serial
// remainder unit, which retires one bit per cycle. A new candidate is
// taken once the previous one has finished; its result may still wait in
// the output register meanwhile.
module trial_division_prime_test_top #(
  parameter int WIDTH = tdpt_pkg::WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tdpt_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] candidate
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tdpt_pkg::OUT_TDATA_W-1:0]   m_tdata    // [0] is_prime, [7:1] zero
);

  // value width actually tested: candidates never exceed 32 bits
  localparam int VW = (WIDTH < tdpt_pkg::CANDIDATE_W) ? WIDTH : tdpt_pkg::CANDIDATE_W;

  tdpt_pkg::dp_cmd_t  cmd;
  tdpt_pkg::dp_stat_t stat;

  tdpt_datapath #(
    .VW(VW)
  ) u_datapath (
    .clk       (clk),
    .candidate (s_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  tdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  // one candidate at a time: no second beat right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a test is in progress");

  // datapath commands never overlap
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.next_div}))
    else $error("overlapping datapath commands");

  // pad bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[tdpt_pkg::OUT_TDATA_W-1:1] == '0))
    else $error("nonzero pad bits in result");

endmodule

/* sv/tdpt_datapath.sv */
`timescale 1ns / 1ps

module tdpt_datapath #(
  parameter int VW = tdpt_pkg::CANDIDATE_W
) (
  input  logic                                clk,
  input  logic [tdpt_pkg::CANDIDATE_W-1:0]    candidate,
  input  tdpt_pkg::dp_cmd_t                   cmd,
  output tdpt_pkg::dp_stat_t                  stat
);

  // divisor width covers sqrt of the largest value plus one step
  localparam int DW = (VW + 1) / 2 + 1;
  localparam int SW = 2 * DW;
  localparam int CW = (VW > 1) ? $clog2(VW) : 1;

  logic [VW-1:0] value;
  logic [DW-1:0] divisor;
  logic [SW-1:0] square;
  logic [DW:0]   rem;
  logic [VW-1:0] shreg;
  logic [CW-1:0] cnt;

  logic [DW:0]   rem_shift;
  logic [DW:0]   rem_sub;
  logic          rem_ge;
  logic [DW:0]   rem_next;

  // one restoring-division bit: shift in the next value bit, subtract if it fits
  always_comb begin
    rem_shift = {rem[DW-1:0], shreg[VW-1]};
    rem_ge    = rem_shift >= {1'b0, divisor};
    rem_sub   = rem_shift - {1'b0, divisor};
    rem_next  = rem_ge ? rem_sub : rem_shift;
  end

  // candidate, divisor and its square
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value   <= candidate[VW-1:0];
      divisor <= DW'(tdpt_pkg::FIRST_DIVISOR);
      square  <= SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
    end else if (cmd.next_div) begin
      // (d + 2)^2 = d^2 + 4d + 4
      divisor <= divisor + DW'(tdpt_pkg::DIVISOR_STEP);
      square  <= square + (SW'(divisor) << 2) + SW'(4);
    end
  end

  // bit-serial remainder unit
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem   <= '0;
      shreg <= value;
      cnt   <= '0;
    end else if (cmd.div_step) begin
      rem   <= rem_next;
      shreg <= shreg << 1;
      cnt   <= cnt + CW'(1);
    end
  end

  // status back to the controller
  always_comb begin
    stat.lt_two   = value < VW'(2);
    stat.is_two   = value == VW'(2);
    stat.is_even  = ~value[0];
    stat.sq_le    = square <= SW'(value);
    stat.div_last = cnt == CW'(VW - 1);
    stat.rem_zero = rem == '0;
  end

endmodule

/* sv/tdpt_ctrl.sv */
`timescale 1ns / 1ps

module tdpt_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tdpt_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [0] is_prime, rest zero
  output tdpt_pkg::dp_cmd_t                  cmd,
  input  tdpt_pkg::dp_stat_t                 stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_CHECK,
    S_DIV,
    S_EVAL,
    S_DONE
  } state_t;

  state_t state;
  logic   res;

  assign s_tready = state == S_IDLE;

  // datapath commands decoded from state and status
  always_comb begin
    cmd.load      = (state == S_IDLE) && s_tvalid;
    cmd.div_start = (state == S_CHECK) && stat.sq_le;
    cmd.div_step  = state == S_DIV;
    cmd.next_div  = (state == S_EVAL) && !stat.rem_zero;
  end

  // state, pending result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res      <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      // a finished result keeps the output beat valid, else it drops once taken
      if (state == S_DONE) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CLASS;
          end
        end
        // zero, one, two and even values need no division
        S_CLASS: begin
          if (stat.lt_two || (stat.is_even && !stat.is_two)) begin
            res   <= 1'b0;
            state <= S_DONE;
          end else if (stat.is_two) begin
            res   <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.sq_le) begin
            state <= S_DIV;
          end else begin
            res   <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (stat.div_last) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (stat.rem_zero) begin
            res   <= 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {{(tdpt_pkg::OUT_TDATA_W-1){1'b0}}, res};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
